// File: sv/decision_forest_inference_unit_macros.svh
// Assertion helpers for the inference unit
`ifndef DECISION_FOREST_INFERENCE_UNIT_MACROS_SVH
`define DECISION_FOREST_INFERENCE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define DFI_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define DFI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also covers reset
`define DFI_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/dfi_pkg.sv
package dfi_pkg;

  localparam int NODE_DEPTH = 4096;
  localparam int LEAF_DEPTH = 4096;
  localparam int TREE_DEPTH = 256;
  localparam int ATTR_DEPTH = 256;
  localparam int WALK_LIMIT = 64;

  localparam int NODE_AW = $clog2(NODE_DEPTH);
  localparam int LEAF_AW = $clog2(LEAF_DEPTH);
  localparam int TREE_AW = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
  localparam int ATTR_AW = (ATTR_DEPTH > 1) ? $clog2(ATTR_DEPTH) : 1;
  localparam int STEP_W  = $clog2(WALK_LIMIT + 1);
  localparam int SUM_W   = 32 + $clog2(TREE_DEPTH + 1) + 1;
  localparam int PROD_W  = SUM_W + 18;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_NODE = 2'd0,
    CMD_LEAF = 2'd1,
    CMD_ROOT = 2'd2,
    CMD_FEAT = 2'd3
  } cmd_t;

  localparam logic [1:0] CFG_TREE_COUNT = 2'd0;
  localparam logic [1:0] CFG_ATTR_COUNT = 2'd1;
  localparam logic [1:0] CFG_TREE_RECIP = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_WALK = 2'd1;
  localparam logic [1:0] STAT_ATTR = 2'd2;
  localparam logic [1:0] STAT_LEN  = 2'd3;

  typedef struct packed {
    cmd_t               cmd;
    logic [11:0]        index;
    logic signed [12:0] left_next;
    logic signed [12:0] right_next;
    logic [7:0]         attribute;
    logic [11:0]        root_node;
    logic signed [31:0] value;
    logic               last;
  } item_t;

  typedef struct packed {
    logic signed [12:0] left;
    logic signed [12:0] right;
    logic [7:0]         attr;
    logic signed [31:0] thr;
  } node_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_ROOT_W,
    S_NODE,
    S_NODE_W,
    S_FEAT_W,
    S_LEAF,
    S_LEAF_W,
    S_MUL,
    S_SAT,
    S_OUT
  } eng_state_t;

endpackage

// File: sv/dfi_queue.sv
module dfi_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_stall,
  input  dfi_pkg::item_t push_item,
  output logic          pop_valid,
  input  logic          pop_en,
  output dfi_pkg::item_t pop_item
);
  import dfi_pkg::*;

  item_t                slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]    count_r, count_nxt;
  logic                 push, pop;

  assign push_stall = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_en && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: sv/dfi_engine.sv
module dfi_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_data,
  input  logic                pop_valid,
  output logic                pop_en,
  input  dfi_pkg::item_t      pop_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_prediction,
  output logic [1:0]          out_status
);
  import dfi_pkg::*;

  node_t              node_mem [NODE_DEPTH];
  logic signed [31:0] leaf_mem [LEAF_DEPTH];
  logic [11:0]        root_mem [TREE_DEPTH];
  logic signed [31:0] feat_mem [ATTR_DEPTH];

  node_t              node_q;
  logic signed [31:0] leaf_q;
  logic [11:0]        root_q;
  logic signed [31:0] feat_q;

  logic [8:0]  tree_count_r, attr_count_r;
  logic [16:0] recip_r;

  eng_state_t          state_r, state_nxt;
  logic [8:0]          feat_count_r, feat_count_nxt;
  logic [8:0]          t_r, t_nxt;
  logic [8:0]          trees_r, trees_nxt;
  logic [12:0]         node_r, node_nxt;
  logic [LEAF_AW-1:0]  leaf_r, leaf_nxt;
  logic [STEP_W-1:0]   steps_r, steps_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [31:0]  pred_r, pred_nxt;
  logic [1:0]          stat_r, stat_nxt;
  logic                out_valid_r;
  logic signed [31:0]  out_pred_r;
  logic [1:0]          out_stat_r;

  logic                node_we, leaf_we, root_we, feat_we;
  logic [9:0]          received;
  logic signed [12:0]  next_child;
  logic [12:0]         leaf_mag;
  logic signed [PROD_W-1:0] shifted;
  logic                load_out;

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;
  assign out_status     = out_stat_r;
  assign load_out       = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign received       = {1'b0, feat_count_r} + 10'd1;
  assign next_child     = (feat_q < node_q.thr) ? node_q.left : node_q.right;
  assign leaf_mag       = 13'(-next_child);
  assign shifted        = prod_r >>> 16;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tree_count_r <= 9'd1;
      attr_count_r <= 9'd1;
      recip_r      <= 17'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TREE_COUNT: tree_count_r <= cfg_data[8:0];
        CFG_ATTR_COUNT: attr_count_r <= cfg_data[8:0];
        CFG_TREE_RECIP: recip_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    feat_count_nxt = feat_count_r;
    t_nxt          = t_r;
    trees_nxt      = trees_r;
    node_nxt       = node_r;
    leaf_nxt       = leaf_r;
    steps_nxt      = steps_r;
    sum_nxt        = sum_r;
    pred_nxt       = pred_r;
    stat_nxt       = stat_r;
    pop_en         = 1'b0;
    node_we        = 1'b0;
    leaf_we        = 1'b0;
    root_we        = 1'b0;
    feat_we        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        pop_en = pop_valid;
        if (pop_valid) begin
          unique case (pop_item.cmd)
            CMD_NODE: node_we = (32'(pop_item.index) < NODE_DEPTH);
            CMD_LEAF: leaf_we = (32'(pop_item.index) < LEAF_DEPTH);
            CMD_ROOT: root_we = (32'(pop_item.index) < TREE_DEPTH);
            CMD_FEAT: begin
              feat_we = (32'(feat_count_r) < ATTR_DEPTH);
              if (!pop_item.last) begin
                feat_count_nxt = received[9] ? 9'd511 : received[8:0];
              end else begin
                feat_count_nxt = '0;
                pred_nxt       = '0;
                stat_nxt       = STAT_OK;
                sum_nxt        = '0;
                t_nxt          = '0;
                trees_nxt      = (32'(tree_count_r) > TREE_DEPTH) ?
                                 9'(TREE_DEPTH) : tree_count_r;
                if (received != {1'b0, attr_count_r} ||
                    32'(attr_count_r) > ATTR_DEPTH) begin
                  stat_nxt  = STAT_LEN;
                  state_nxt = S_OUT;
                end else if (trees_nxt == '0) begin
                  state_nxt = S_OUT;
                end else begin
                  state_nxt = S_ROOT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_ROOT:   state_nxt = S_ROOT_W;
      S_ROOT_W: begin
        node_nxt  = 13'(root_q);
        steps_nxt = '0;
        state_nxt = S_NODE;
      end
      S_NODE: begin
        if (steps_r == STEP_W'(WALK_LIMIT) || 32'(node_r) >= NODE_DEPTH) begin
          stat_nxt  = STAT_WALK;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_NODE_W;
        end
      end
      S_NODE_W: begin
        if ({1'b0, node_q.attr} >= attr_count_r || 32'(node_q.attr) >= ATTR_DEPTH) begin
          stat_nxt  = STAT_ATTR;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_FEAT_W;
        end
      end
      S_FEAT_W: begin
        if (next_child[12]) begin
          if (32'(leaf_mag) >= LEAF_DEPTH) begin
            stat_nxt  = STAT_WALK;
            state_nxt = S_OUT;
          end else begin
            leaf_nxt  = LEAF_AW'(leaf_mag);
            state_nxt = S_LEAF;
          end
        end else begin
          node_nxt  = 13'(next_child);
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_NODE;
        end
      end
      S_LEAF:   state_nxt = S_LEAF_W;
      S_LEAF_W: begin
        sum_nxt = sum_r + SUM_W'(leaf_q);
        if (t_r + 9'd1 == trees_r) begin
          state_nxt = S_MUL;
        end else begin
          t_nxt     = t_r + 9'd1;
          state_nxt = S_ROOT;
        end
      end
      S_MUL:    state_nxt = S_SAT;
      S_SAT: begin
        if (shifted[PROD_W-1:31] == '0 || shifted[PROD_W-1:31] == '1) begin
          pred_nxt = shifted[31:0];
        end else if (shifted[PROD_W-1]) begin
          pred_nxt = 32'sh8000_0000;
        end else begin
          pred_nxt = 32'sh7fff_ffff;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      feat_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      feat_count_r <= feat_count_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    trees_r <= trees_nxt;
    node_r  <= node_nxt;
    leaf_r  <= leaf_nxt;
    steps_r <= steps_nxt;
    sum_r   <= sum_nxt;
    pred_r  <= pred_nxt;
    stat_r  <= stat_nxt;
    prod_r  <= sum_r * $signed({1'b0, recip_r});
    if (load_out) begin
      out_pred_r <= (stat_r == STAT_OK) ? pred_r : '0;
      out_stat_r <= stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[NODE_AW'(pop_item.index)] <= '{left: pop_item.left_next,
                                             right: pop_item.right_next,
                                             attr: pop_item.attribute,
                                             thr: pop_item.value};
    end
    node_q <= node_mem[NODE_AW'(node_r)];
  end

  always_ff @(posedge clk) begin
    if (leaf_we) begin
      leaf_mem[LEAF_AW'(pop_item.index)] <= pop_item.value;
    end
    leaf_q <= leaf_mem[leaf_r];
  end

  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[TREE_AW'(pop_item.index)] <= pop_item.root_node;
    end
    root_q <= root_mem[TREE_AW'(t_r)];
  end

  always_ff @(posedge clk) begin
    if (feat_we) begin
      feat_mem[ATTR_AW'(feat_count_r)] <= pop_item.value;
    end
    feat_q <= feat_mem[ATTR_AW'(node_q.attr)];
  end

endmodule

// File: sv/decision_forest_inference_unit.sv
// Tree-ensemble inference unit, Q16.16 fixed point.
// Input channel (in_valid / in_stall): each request writes a node, a leaf
// score or a tree root, or streams one feature; in_last on a feature request
// closes the instance and starts the evaluation.
// Output channel (out_valid / out_stall): one result per closing feature,
// prediction plus status; prediction is 0 when status is not ok.
// Configuration: cfg_we writes tree_count (0), attribute_count (1) or
// tree_reciprocal (2) from cfg_data; write only while the unit is idle.
// A four-entry request queue decouples the input from the engine.
// Table and feature requests are taken straight from the queue while idle. A
// closing feature walks each tree from its root, reading node then feature per
// step, sums leaf scores, scales by tree_reciprocal, saturates, then outputs.
// Reset (rst_n low, synchronous) empties the queue, clears the feature count,
// restores register defaults; table contents are kept but undefined until
// written. A stalled result holds in the output register; the engine then
// waits, the queue fills and in_stall rises once it holds four requests.
module decision_forest_inference_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [11:0]        in_index,
  input  logic signed [12:0] in_left_next,
  input  logic signed [12:0] in_right_next,
  input  logic [7:0]         in_attribute,
  input  logic [11:0]        in_root_node,
  input  logic signed [31:0] in_value,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_prediction,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data
);
  import dfi_pkg::*;

  item_t in_item, pop_item;
  logic  pop_valid, pop_en;

  always_comb begin
    in_item.cmd        = cmd_t'(in_cmd);
    in_item.index      = in_index;
    in_item.left_next  = in_left_next;
    in_item.right_next = in_right_next;
    in_item.attribute  = in_attribute;
    in_item.root_node  = in_root_node;
    in_item.value      = in_value;
    in_item.last       = in_last;
  end

  dfi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_item  (in_item),
    .pop_valid  (pop_valid),
    .pop_en     (pop_en),
    .pop_item   (pop_item)
  );

  dfi_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pop_valid      (pop_valid),
    .pop_en         (pop_en),
    .pop_item       (pop_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prediction (out_prediction),
    .out_status     (out_status)
  );

endmodule

// File: sv/dfi_checker.sv
`include "decision_forest_inference_unit_macros.svh"

module dfi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_prediction,
  input logic [1:0]         out_status
);
  import dfi_pkg::*;

  `DFI_ASSERT(a_fault_zero, out_valid && out_status != STAT_OK, out_prediction == '0)
  `DFI_ASSERT_NEXT(a_stall_hold, out_valid && out_stall,
                   out_valid && $stable(out_prediction) && $stable(out_status))
  `DFI_ASSERT_RST(a_reset_empty, !rst_n, !out_valid)

endmodule

bind decision_forest_inference_unit dfi_checker u_dfi_checker (.*);

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dfi_pkg::*;

  localparam int POOL = 64;
  localparam int TOP_IDX = 4095;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] prediction;
    logic [1:0]         status;
  } score_t;

  class forest_scoreboard;
    int unsigned trees_cfg = 1;
    int unsigned attrs_cfg = 1;
    int unsigned recip_cfg = 65536;
    logic signed [12:0] lchild [NODE_DEPTH];
    logic signed [12:0] rchild [NODE_DEPTH];
    logic [7:0]         nattr [NODE_DEPTH];
    logic signed [31:0] thr [NODE_DEPTH];
    logic signed [31:0] leaf [LEAF_DEPTH];
    logic [11:0]        root [TREE_DEPTH];
    logic signed [31:0] feat [ATTR_DEPTH];
    int unsigned feat_cnt = 0;
    score_t pending[$];
    int errors = 0;
    int results = 0;
    int status_hits [4];

    function void set_cfg(logic [1:0] idx, logic [16:0] data);
      if (idx == CFG_TREE_COUNT) trees_cfg = data[8:0];
      else if (idx == CFG_ATTR_COUNT) attrs_cfg = data[8:0];
      else if (idx == CFG_TREE_RECIP) recip_cfg = data;
    endfunction

    function score_t evaluate(int unsigned received);
      score_t r;
      longint acc;
      longint q;
      int trees;
      int node;
      int nxt;
      int a;
      bit done;
      acc = 0;
      r.prediction = 0;
      r.status = STAT_OK;
      trees = (trees_cfg > TREE_DEPTH) ? TREE_DEPTH : trees_cfg;
      if (received != attrs_cfg || attrs_cfg > ATTR_DEPTH) begin
        r.status = STAT_LEN;
        return r;
      end
      for (int t = 0; t < trees; t++) begin
        node = root[t];
        done = 0;
        for (int s = 0; s < WALK_LIMIT && !done; s++) begin
          a = nattr[node];
          if (a >= attrs_cfg) begin
            r.status = STAT_ATTR;
            done = 1;
          end else begin
            nxt = (feat[a] < thr[node]) ? int'(lchild[node]) : int'(rchild[node]);
            if (nxt < 0) begin
              acc += longint'(leaf[-nxt]);
              done = 1;
            end else begin
              node = nxt;
            end
          end
        end
        if (!done) r.status = STAT_WALK;
        if (r.status != STAT_OK) return r;
      end
      q = (acc * longint'(recip_cfg)) >>> 16;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      r.prediction = q[31:0];
      return r;
    endfunction

    function void note_request(item_t it);
      int unsigned got;
      case (it.cmd)
        CMD_NODE: begin
          lchild[it.index] = it.left_next;
          rchild[it.index] = it.right_next;
          nattr[it.index] = it.attribute;
          thr[it.index] = it.value;
        end
        CMD_LEAF: leaf[it.index] = it.value;
        CMD_ROOT: if (it.index < TREE_DEPTH) root[it.index] = it.root_node;
        default: begin
          if (feat_cnt < ATTR_DEPTH) feat[feat_cnt] = it.value;
          got = feat_cnt + 1;
          if (!it.last) begin
            feat_cnt = (got > 511) ? 511 : got;
          end else begin
            pending.push_back(evaluate(got));
            feat_cnt = 0;
          end
        end
      endcase
    endfunction

    function void check_result(logic signed [31:0] pred, logic [1:0] st);
      score_t e;
      results++;
      status_hits[st]++;
      if (pending.size() == 0) begin
        $error("unexpected result: prediction %0d status %0d", pred, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pred !== e.prediction) begin
        $error("prediction: expected %0d actual %0d", e.prediction, pred);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_cmd = 0;
  logic [11:0] in_index = 0;
  logic signed [12:0] in_left_next = 0;
  logic signed [12:0] in_right_next = 0;
  logic [7:0] in_attribute = 0;
  logic [11:0] in_root_node = 0;
  logic signed [31:0] in_value = 0;
  logic in_last = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_prediction;
  logic [1:0] out_status;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [16:0] cfg_data = 0;

  forest_scoreboard sb = new();
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  longint cycles = 0;
  int requests = 0;

  decision_forest_inference_unit u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < out_idle_pct);

  always @(posedge clk)
    if (rst_n && out_valid && !out_stall) sb.check_result(out_prediction, out_status);

  task automatic send(item_t it);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_cmd <= it.cmd;
    in_index <= it.index;
    in_left_next <= it.left_next;
    in_right_next <= it.right_next;
    in_attribute <= it.attribute;
    in_root_node <= it.root_node;
    in_value <= it.value;
    in_last <= it.last;
    do @(posedge clk); while (in_stall);
    sb.note_request(it);
    requests++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain();
    go_quiet();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] data);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_cfg(idx, data);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t noise(cmd_t c);
    item_t it;
    it.cmd = c;
    it.index = $urandom;
    it.left_next = $urandom;
    it.right_next = $urandom;
    it.attribute = $urandom;
    it.root_node = $urandom;
    it.value = $urandom;
    it.last = $urandom;
    return it;
  endfunction

  function automatic int pool_node();
    return ($urandom_range(15) == 0) ? TOP_IDX : $urandom_range(POOL - 1);
  endfunction

  function automatic logic signed [12:0] child_of(int i);
    int l;
    l = ($urandom_range(20) == 0) ? TOP_IDX : $urandom_range(POOL - 1, 1);
    if (i == TOP_IDX || i >= POOL - 1 || $urandom_range(9) < 6) return -l;
    if ($urandom_range(29) == 0) return $urandom_range(i);
    return $urandom_range(POOL - 1, i + 1);
  endfunction

  function automatic item_t node_req(int i);
    item_t it;
    int span;
    it = noise(CMD_NODE);
    span = (sb.attrs_cfg == 0) ? 1 : (sb.attrs_cfg > ATTR_DEPTH ? ATTR_DEPTH : sb.attrs_cfg);
    it.index = i;
    it.left_next = child_of(i);
    it.right_next = child_of(i);
    it.attribute = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(span - 1);
    it.value = pick_value();
    return it;
  endfunction

  function automatic item_t leaf_req(int i, logic signed [31:0] v);
    item_t it;
    it = noise(CMD_LEAF);
    it.index = i;
    it.value = v;
    return it;
  endfunction

  function automatic item_t root_req(int t, int n);
    item_t it;
    it = noise(CMD_ROOT);
    it.index = t;
    it.root_node = n;
    return it;
  endfunction

  function automatic item_t feature(logic signed [31:0] v, bit fin);
    item_t it;
    it = noise(CMD_FEAT);
    it.value = v;
    it.last = fin;
    return it;
  endfunction

  task automatic send_instance(int n);
    for (int k = 0; k < n; k++) send(feature(pick_value(), k == n - 1));
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL; i++) send(node_req(i));
    send(node_req(TOP_IDX));
  endtask

  int tc_set [9] = '{1, 4, 256, 0, 511, 2, 3, 8, 16};
  int ac_set [9] = '{1, 6, 3, 2, 256, 511, 0, 5, 4};
  int rc_set [9] = '{65536, 16384, 256, 0, 65535, 100, 40000, 65536, 8192};

  initial begin
    item_t it;
    int sent;
    int n;
    int r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    refresh_pool();
    for (int i = 0; i < POOL; i++) send(leaf_req(i, pick_value()));
    send(leaf_req(TOP_IDX, 32'sh7fffffff));
    for (int t = 0; t < TREE_DEPTH; t++) send(root_req(t, pool_node()));

    // hand-built cases under the reset configuration
    send(root_req(0, TOP_IDX));
    it = node_req(TOP_IDX);
    it.left_next = -13'sd4095;
    it.right_next = -13'sd1;
    it.attribute = 8'd255;
    it.value = 32'sh80000000;
    send(it);
    send(feature(32'sh7fffffff, 1));
    it.attribute = 0;
    it.value = 0;
    send(it);
    send(feature(-32'sd1, 1));
    send(feature(32'sh80000000, 1));
    send(feature(32'sh7fffffff, 0));
    send(feature(32'sh7fffffff, 1));
    it = node_req(POOL - 2);
    it.left_next = POOL - 2;
    it.right_next = POOL - 2;
    it.attribute = 0;
    send(it);
    send(root_req(0, POOL - 2));
    send(feature(0, 1));
    send(node_req(POOL - 2));
    send(root_req(0, 0));
    send(root_req(TOP_IDX, 5));
    send(leaf_req(1, 32'sh80000000));
    send_instance(1);
    drain();

    for (int p = 0; p < 9; p++) begin
      in_idle_pct = (p < 3) ? 26 : (p < 6 ? 45 : 0);
      out_idle_pct = (p < 3) ? 45 : (p < 6 ? 26 : 0);
      write_reg(CFG_TREE_COUNT, tc_set[p]);
      write_reg(CFG_ATTR_COUNT, ac_set[p]);
      write_reg(CFG_TREE_RECIP, rc_set[p]);
      if (ac_set[p] >= 1 && ac_set[p] <= ATTR_DEPTH) refresh_pool();
      if (ac_set[p] > ATTR_DEPTH) send_instance(520);
      sent = 0;
      while (sent < 40) begin
        r = $urandom_range(99);
        if (p == 1 && sent >= 20 && sent < 22) drain();
        if (r < 15) begin
          send(node_req(pool_node()));
          n = 1;
        end else if (r < 20) begin
          send(leaf_req(($urandom_range(1) ? $urandom_range(4095) : $urandom_range(POOL - 1)),
                        pick_value()));
          n = 1;
        end else if (r < 25) begin
          send(root_req($urandom_range(299), pool_node()));
          n = 1;
        end else if (r < 30) begin
          it = noise(CMD_NODE);
          it.index = $urandom_range(TOP_IDX - 1, POOL);
          send(it);
          n = 1;
        end else begin
          if (r < 36 || ac_set[p] == 0 || ac_set[p] > ATTR_DEPTH)
            n = (ac_set[p] > 1 && ac_set[p] <= 8 && $urandom_range(1)) ? ac_set[p] - 1
                : (ac_set[p] <= 8 ? ac_set[p] + 1 : $urandom_range(5, 1));
          else
            n = ac_set[p];
          send_instance(n);
        end
        sent += n;
      end
      drain();
    end

    in_idle_pct = 0;
    go_quiet();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    $display("Covered %0d requests, %0d results over 9 register settings", requests, sb.results);
    $display("Status counts: ok %0d, walk %0d, attribute %0d, length %0d",
             sb.status_hits[STAT_OK], sb.status_hits[STAT_WALK],
             sb.status_hits[STAT_ATTR], sb.status_hits[STAT_LEN]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/dfi_pkg.sv
sv/dfi_queue.sv
sv/dfi_engine.sv
sv/decision_forest_inference_unit.sv
sv/dfi_checker.sv
tb/testbench.sv
